/* src/nearest_landmark_ring_emit_unit_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef NEAREST_LANDMARK_RING_EMIT_UNIT_ASSERT_SVH
`define NEAREST_LANDMARK_RING_EMIT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NLRE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NLRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/nlre_pkg.sv */
package nlre_pkg;

  localparam int COORD_BITS    = 24;
  localparam int TRIG_BITS     = 16;
  localparam int WANT_BITS     = 7;
  localparam int MAX_CONES_DEF = 64;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = COORD_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_VEHICLE_POS_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VEHICLE_POS_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BEARING_COS   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BEARING_SIN   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CONES_WANTED  = 3'd4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cone_pos_x;
    logic signed [COORD_BITS-1:0] cone_pos_y;
    logic                         final_cone;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] rel_x;
    logic signed [COORD_BITS-1:0] rel_y;
    logic                         last_of_run;
    logic                         start_in_view;
    logic                         none_found;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vehicle_pos_x;
    logic signed [COORD_BITS-1:0] vehicle_pos_y;
    logic signed [TRIG_BITS-1:0]  bearing_cos;
    logic signed [TRIG_BITS-1:0]  bearing_sin;
    logic [WANT_BITS-1:0]         cones_wanted;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic final_done;
    logic out_free;
    logic run_last;
  } dp_status_t;

endpackage

/* src/nearest_landmark_ring_emit_unit.sv */
// Landmark loader with nearest search and circular run output. Landmarks enter one per
// cycle while loading; each is translated by the vehicle position, rotated by the heading
// cosine and sine (Q2.14, rounded and saturated to 1/256 m) and written to an on-chip
// store, while the nearest landmark with a nonzero squared distance is tracked (ties keep
// the earlier one). The load path is a five-stage pipeline: subtract, four multiplies,
// add/round/saturate with the store write, two squares, and the distance compare. After
// the transaction marked final, the input stalls while the pipeline drains and the run is
// set up; then min(cones_wanted, count) results (a zero cones_wanted counts as one) leave
// at one per cycle when the output is not stalled, paced by the single read port of the
// store, which feeds the output register directly. The input stays stalled until the
// last result of the run has been issued. If no landmark qualifies a single zero result
// flagged none_found is given. Landmarks beyond MAX_CONES are dropped. Configuration may
// be written at any time the block is idle and is always ready; the store needs no
// clearing pass after reset.
module nearest_landmark_ring_emit_unit #(
  parameter int MAX_CONES = nlre_pkg::MAX_CONES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  nlre_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output nlre_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [nlre_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [nlre_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  nlre_pkg::cfg_t       cfg;
  nlre_pkg::ctrl_cmd_t  cmd;
  nlre_pkg::dp_status_t status;

  // Configuration registers take every write transaction at once.
  assign cfg_ready_o = 1'b1;

  nlre_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The controller sequences loading, draining, run setup and the emission of results.
  nlre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_final_i (in_data_i.final_cone),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // The datapath holds the load pipeline, the landmark store and the output register.
  nlre_dp #(
    .MAX_CONES (MAX_CONES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* src/nlre_cfg.sv */
module nlre_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [nlre_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [nlre_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output nlre_pkg::cfg_t                      cfg_o
);

  nlre_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vehicle_pos_x <= '0;
      cfg_q.vehicle_pos_y <= '0;
      cfg_q.bearing_cos   <= 16'sd16384;
      cfg_q.bearing_sin   <= '0;
      cfg_q.cones_wanted  <= 7'd8;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        nlre_pkg::CFG_VEHICLE_POS_X: begin
          cfg_q.vehicle_pos_x <= cfg_data_i[nlre_pkg::COORD_BITS-1:0];
        end
        nlre_pkg::CFG_VEHICLE_POS_Y: begin
          cfg_q.vehicle_pos_y <= cfg_data_i[nlre_pkg::COORD_BITS-1:0];
        end
        nlre_pkg::CFG_BEARING_COS: begin
          cfg_q.bearing_cos <= cfg_data_i[nlre_pkg::TRIG_BITS-1:0];
        end
        nlre_pkg::CFG_BEARING_SIN: begin
          cfg_q.bearing_sin <= cfg_data_i[nlre_pkg::TRIG_BITS-1:0];
        end
        nlre_pkg::CFG_CONES_WANTED: begin
          cfg_q.cones_wanted <= cfg_data_i[nlre_pkg::WANT_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/nlre_ctrl.sv */
module nlre_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_final_i,
  input  nlre_pkg::dp_status_t    status_i,
  output logic                    in_stall_o,
  output nlre_pkg::ctrl_cmd_t     cmd_o
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_SETUP = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.setup  = 1'b0;
    cmd_o.emit   = 1'b0;
    case (state_q)
      ST_LOAD: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && in_final_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.final_done) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.run_last) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_LOAD);

endmodule

/* src/nlre_dp.sv */
module nlre_dp #(
  parameter int MAX_CONES = nlre_pkg::MAX_CONES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  nlre_pkg::cfg_t          cfg_i,
  input  nlre_pkg::in_item_t      in_data_i,
  input  nlre_pkg::ctrl_cmd_t     cmd_i,
  output nlre_pkg::dp_status_t    status_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output nlre_pkg::out_item_t     out_data_o
);

  localparam int C      = nlre_pkg::COORD_BITS;
  localparam int T      = nlre_pkg::TRIG_BITS;
  localparam int W      = nlre_pkg::WANT_BITS;
  localparam int IDX_W  = $clog2(MAX_CONES);
  localparam int CNT_W  = $clog2(MAX_CONES + 1);
  localparam int DX_W   = C + 1;
  localparam int PROD_W = T + DX_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int DIST_W = 2 * C;
  localparam int FRAC_W = 14;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0] COORD_MAX  = (SUM_W'(1) << (C - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] COORD_MIN  = -COORD_MAX - SUM_W'(1);

  // Load pipeline.
  logic                     v1_q, v2_q, v3_q, v4_q;
  logic                     st1_q, st2_q, st3_q, st4_q;
  logic                     last1_q, last2_q, last3_q, last4_q;
  logic [IDX_W-1:0]         idx1_q, idx2_q, idx3_q, idx4_q;
  logic signed [DX_W-1:0]   dx_q, dy_q;
  logic signed [PROD_W-1:0] p_cx_q, p_sy_q, p_cy_q, p_sx_q;
  logic signed [C-1:0]      lx_q, ly_q;
  logic signed [DIST_W-1:0] sq_x_q, sq_y_q;

  logic [CNT_W-1:0]         count_q;
  logic [IDX_W-1:0]         near_idx_q;
  logic [DIST_W-1:0]        near_dist_q;
  logic                     near_valid_q;

  logic [CNT_W-1:0]         rem_q;
  logic [IDX_W-1:0]         ptr_q;
  logic                     in_view_q;
  logic                     none_q;

  logic                     out_valid_q;
  nlre_pkg::out_item_t      out_q;

  logic [2*C-1:0]           store_q [MAX_CONES];

  logic                     store_en;
  logic signed [DX_W-1:0]   dx_d, dy_d;
  logic signed [SUM_W-1:0]  sum_x, sum_y, rnd_x, rnd_y;
  logic signed [C-1:0]      lx_d, ly_d;
  logic [DIST_W-1:0]        sum_sq;
  logic                     take_near;
  logic                     clear_list;
  logic [W-1:0]             wanted_eff, count_ext;
  logic [CNT_W-1:0]         run_len;
  logic [CNT_W:0]           end_pos;
  logic                     in_view_d;
  logic [CNT_W-1:0]         ptr_inc;
  logic                     run_last;

  assign store_en = (count_q < CNT_W'(MAX_CONES));

  assign dx_d = {in_data_i.cone_pos_x[C-1], in_data_i.cone_pos_x}
              - {cfg_i.vehicle_pos_x[C-1], cfg_i.vehicle_pos_x};
  assign dy_d = {in_data_i.cone_pos_y[C-1], in_data_i.cone_pos_y}
              - {cfg_i.vehicle_pos_y[C-1], cfg_i.vehicle_pos_y};

  assign sum_x = {p_cx_q[PROD_W-1], p_cx_q} + {p_sy_q[PROD_W-1], p_sy_q};
  assign sum_y = {p_cy_q[PROD_W-1], p_cy_q} - {p_sx_q[PROD_W-1], p_sx_q};
  // Round half up, then floor: an arithmetic shift gives the floor.
  assign rnd_x = (sum_x + ROUND_HALF) >>> FRAC_W;
  assign rnd_y = (sum_y + ROUND_HALF) >>> FRAC_W;

  assign lx_d = (rnd_x > COORD_MAX) ? COORD_MAX[C-1:0] :
                (rnd_x < COORD_MIN) ? COORD_MIN[C-1:0] : rnd_x[C-1:0];
  assign ly_d = (rnd_y > COORD_MAX) ? COORD_MAX[C-1:0] :
                (rnd_y < COORD_MIN) ? COORD_MIN[C-1:0] : rnd_y[C-1:0];

  assign sum_sq    = $unsigned(sq_x_q) + $unsigned(sq_y_q);
  assign take_near = v4_q && st4_q && (sum_sq != '0)
                     && (!near_valid_q || sum_sq < near_dist_q);

  assign run_last   = none_q || (rem_q == CNT_W'(1));
  assign clear_list = cmd_i.emit && run_last;

  assign wanted_eff = (cfg_i.cones_wanted == '0) ? W'(1) : cfg_i.cones_wanted;
  assign count_ext  = W'(count_q);
  assign run_len    = (wanted_eff > count_ext) ? count_q : CNT_W'(wanted_eff);
  assign end_pos    = {1'b0, CNT_W'(near_idx_q)} + {1'b0, run_len};
  assign in_view_d  = (near_idx_q == '0) || (end_pos > {1'b0, count_q});
  assign ptr_inc    = CNT_W'(ptr_q) + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      st1_q   <= store_en;
      last1_q <= in_data_i.final_cone;
      idx1_q  <= count_q[IDX_W-1:0];
    end
    p_cx_q  <= $signed(cfg_i.bearing_cos) * dx_q;
    p_sy_q  <= $signed(cfg_i.bearing_sin) * dy_q;
    p_cy_q  <= $signed(cfg_i.bearing_cos) * dy_q;
    p_sx_q  <= $signed(cfg_i.bearing_sin) * dx_q;
    st2_q   <= st1_q;
    last2_q <= last1_q;
    idx2_q  <= idx1_q;
    lx_q    <= lx_d;
    ly_q    <= ly_d;
    st3_q   <= st2_q;
    last3_q <= last2_q;
    idx3_q  <= idx2_q;
    sq_x_q  <= lx_q * lx_q;
    sq_y_q  <= ly_q * ly_q;
    st4_q   <= st3_q;
    last4_q <= last3_q;
    idx4_q  <= idx3_q;
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && st2_q) begin
      store_q[idx2_q] <= {lx_d, ly_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      near_idx_q   <= '0;
      near_dist_q  <= '1;
      near_valid_q <= 1'b0;
    end else if (clear_list) begin
      count_q      <= '0;
      near_idx_q   <= '0;
      near_dist_q  <= '1;
      near_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && store_en) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (take_near) begin
        near_idx_q   <= idx4_q;
        near_dist_q  <= sum_sq;
        near_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      ptr_q     <= '0;
      in_view_q <= 1'b0;
      none_q    <= 1'b0;
    end else if (cmd_i.setup) begin
      rem_q     <= run_len;
      ptr_q     <= near_idx_q;
      in_view_q <= in_view_d;
      none_q    <= !near_valid_q;
    end else if (cmd_i.emit) begin
      rem_q <= rem_q - CNT_W'(1);
      ptr_q <= (ptr_inc == count_q) ? '0 : ptr_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // The memory read register doubles as the output payload register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (none_q) begin
        out_q.rel_x <= '0;
        out_q.rel_y <= '0;
      end else begin
        {out_q.rel_x, out_q.rel_y} <= store_q[ptr_q];
      end
      out_q.last_of_run   <= run_last;
      out_q.start_in_view <= in_view_q && !none_q;
      out_q.none_found    <= none_q;
    end
  end

  assign status_o.final_done = v4_q && last4_q;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.run_last   = run_last;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/nearest_landmark_ring_emit_unit_chk.sv */
`include "nearest_landmark_ring_emit_unit_assert.svh"

module nearest_landmark_ring_emit_unit_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input nlre_pkg::in_item_t                  in_data_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input nlre_pkg::out_item_t                 out_data_o,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic [nlre_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input logic [nlre_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  // A stalled result holds.
  `NLRE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_data_o), "stalled result changed")

  // An empty run is a single zero result.
  `NLRE_ASSERT_SAME(a_none_shape, clk_i, rst_ni, out_valid_o && out_data_o.none_found,
                    out_data_o.last_of_run && !out_data_o.start_in_view &&
                    out_data_o.rel_x == '0 && out_data_o.rel_y == '0,
                    "none_found result malformed")

  // Input closes after the final landmark.
  `NLRE_ASSERT_NEXT(a_final_stall, clk_i, rst_ni,
                    in_valid_i && !in_stall_o && in_data_i.final_cone, in_stall_o,
                    "input not stalled after final landmark")

  // Within a run the next result follows directly.
  `NLRE_ASSERT_NEXT(a_run_cont, clk_i, rst_ni,
                    out_valid_o && !out_stall_i && !out_data_o.last_of_run, out_valid_o,
                    "gap inside an emitted run")

endmodule

bind nearest_landmark_ring_emit_unit nearest_landmark_ring_emit_unit_chk u_chk (.*);
